// File: hdl/sms_pkg.sv
// ----------------------------------------------------------------------------
// sms_pkg
// Shared constants and types for the sample mean / standard deviation block.
// ----------------------------------------------------------------------------
package sms_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;

   localparam int IDX_W  = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = IDX_W + 1;
   localparam int ADDR_W = IDX_W + 1;           // bank bit + index
   localparam int SUM_W  = SAMPLE_BITS + IDX_W + 1;
   localparam int EST_W  = 48;                  // |sum| << FRAC_BITS
   localparam int ACC_W  = 64;                  // signed Q48.16 working width
   localparam int MAG_W  = 34;                  // |d|, |y| bound
   localparam int HALF_W = MAG_W / 2;
   localparam int M2_W   = 96;
   localparam int DVD_W  = 96;
   localparam int DVS_W  = 32;
   localparam int STEP_W = $clog2(DVD_W + 1);
   localparam int SQ_W   = 64;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_OVF   = 2'd2;

   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] n;
      logic             ovf;
   } job_type;

endpackage

// File: hdl/sms_front.sv
// ----------------------------------------------------------------------------
// sms_front
// Takes sample words into a two-bank sample buffer and closes runs into jobs.
// ----------------------------------------------------------------------------
module sms_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [15:0]                      req_sample,
   input  logic                             req_last_sample,
   input  logic                             job_done,
   output logic                             push,
   output sms_pkg::job_type                 push_job,
   input  logic [sms_pkg::ADDR_W-1:0]       rd_addr,
   output logic [sms_pkg::SAMPLE_BITS-1:0]  rd_data
);

   logic [sms_pkg::SAMPLE_BITS-1:0] mem [2*sms_pkg::MAX_SAMPLES];

   logic [sms_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      ovf_ff, ovf_in;
   logic                      bank_ff, bank_in;
   logic [1:0]                jobs_ff, jobs_in;
   logic                      accept, store;
   logic [sms_pkg::CNT_W-1:0] count_next;

   assign busy   = (jobs_ff == 2'd2);
   assign accept = start & ~busy;
   assign store  = (count_ff < sms_pkg::CNT_W'(sms_pkg::MAX_SAMPLES));
   assign push   = accept & req_last_sample;

   always_comb begin
      count_next = store ? count_ff + 1'b1 : count_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      bank_in    = bank_ff;
      if (accept) begin
         if (req_last_sample) begin
            count_in = '0;
            ovf_in   = 1'b0;
            bank_in  = ~bank_ff;
         end else begin
            count_in = count_next;
            ovf_in   = ovf_ff | ~store;
         end
      end
      jobs_in = jobs_ff + {1'b0, push} - {1'b0, job_done};
      push_job.bank = bank_ff;
      push_job.n    = count_next;
      push_job.ovf  = ovf_ff | ~store;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         bank_ff  <= 1'b0;
         jobs_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         bank_ff  <= bank_in;
         jobs_ff  <= jobs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store) begin
         mem[{bank_ff, count_ff[sms_pkg::IDX_W-1:0]}] <= req_sample[sms_pkg::SAMPLE_BITS-1:0];
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: hdl/sms_queue.sv
// ----------------------------------------------------------------------------
// sms_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module sms_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sms_pkg::job_type push_job,
   input  logic             pop,
   output logic             head_valid,
   output sms_pkg::job_type head_job
);

   sms_pkg::job_type entry_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head_valid = (cnt_ff != 2'd0);
   assign head_job   = entry_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

endmodule

// File: hdl/sms_divider.sv
// ----------------------------------------------------------------------------
// sms_divider
// Restoring unsigned divider, one quotient bit per cycle, MSB-aligned dividend.
// ----------------------------------------------------------------------------
module sms_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            div_start,
   input  logic [sms_pkg::DVD_W-1:0]       dividend,
   input  logic [sms_pkg::DVS_W-1:0]       divisor,
   input  logic [sms_pkg::STEP_W-1:0]      steps,
   output logic                            div_busy,
   output logic                            div_done,
   output logic [sms_pkg::DVD_W-1:0]       quotient
);

   logic [sms_pkg::DVD_W-1:0]  dvd_ff, dvd_in;
   logic [sms_pkg::DVS_W-1:0]  dvs_ff, dvs_in;
   logic [sms_pkg::DVS_W-1:0]  rem_ff, rem_in;
   logic [sms_pkg::DVD_W-1:0]  quo_ff, quo_in;
   logic [sms_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [sms_pkg::DVS_W:0]    rem_sh, rem_sub;
   logic                       ge;

   assign div_busy = run_ff;
   assign div_done = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[sms_pkg::DVD_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_start) begin
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
         quo_in = '0;
         cnt_in = steps;
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[sms_pkg::DVD_W-2:0], 1'b0};
         rem_in = ge ? rem_sub[sms_pkg::DVS_W-1:0] : rem_sh[sms_pkg::DVS_W-1:0];
         quo_in = {quo_ff[sms_pkg::DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == sms_pkg::STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

// File: hdl/sms_back.sv
// ----------------------------------------------------------------------------
// sms_back
// Runs one job: sum pass, mean estimate, Welford pass, variance and root.
// ----------------------------------------------------------------------------
module sms_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  sms_pkg::job_type                 head_job,
   output logic                             pop,
   output logic [sms_pkg::ADDR_W-1:0]       rd_addr,
   input  logic [sms_pkg::SAMPLE_BITS-1:0]  rd_data,
   output logic                             rsp_strobe,
   output logic [31:0]                      rsp_mean,
   output logic [31:0]                      rsp_std_dev,
   output logic [1:0]                       rsp_status
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SUM   = 4'd1;
   localparam logic [3:0] S_EST   = 4'd2;
   localparam logic [3:0] S_ESTW  = 4'd3;
   localparam logic [3:0] S_RD    = 4'd4;
   localparam logic [3:0] S_X     = 4'd5;
   localparam logic [3:0] S_D     = 4'd6;
   localparam logic [3:0] S_DIVS  = 4'd7;
   localparam logic [3:0] S_DIVW  = 4'd8;
   localparam logic [3:0] S_Y     = 4'd9;
   localparam logic [3:0] S_AB    = 4'd10;
   localparam logic [3:0] S_MUL   = 4'd11;
   localparam logic [3:0] S_VAR   = 4'd12;
   localparam logic [3:0] S_VARW  = 4'd13;
   localparam logic [3:0] S_SQRT  = 4'd14;
   localparam logic [3:0] S_OUT   = 4'd15;

   localparam int AW = sms_pkg::ACC_W;
   localparam int SB = sms_pkg::SAMPLE_BITS;
   localparam int HW = sms_pkg::HALF_W;

   logic [3:0]                      state_ff, state_in;
   logic [sms_pkg::CNT_W-1:0]       n_ff, n_in;
   logic                            ovf_ff, ovf_in;
   logic                            bank_ff, bank_in;
   logic [sms_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic [sms_pkg::CNT_W-1:0]       acc_ff, acc_in;
   logic                            rvalid_ff, rvalid_in;
   logic signed [sms_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic signed [AW-1:0]            est_ff, est_in;
   logic signed [AW-1:0]            w_ff, w_in;
   logic signed [AW-1:0]            x_ff, x_in;
   logic signed [AW-1:0]            d_ff, d_in;
   logic signed [AW-1:0]            y_ff, y_in;
   logic [sms_pkg::MAG_W-1:0]       a_ff, a_in;
   logic [sms_pkg::MAG_W-1:0]       b_ff, b_in;
   logic [sms_pkg::M2_W-1:0]        m2_ff, m2_in;
   logic [2:0]                      mcnt_ff, mcnt_in;
   logic [2*HW-1:0]                 prod_ff, prod_in;
   logic [1:0]                      psh_ff, psh_in;
   logic [sms_pkg::SQ_W-1:0]        v_ff, v_in;
   logic [sms_pkg::SQ_W-1:0]        res_ff, res_in;
   logic [sms_pkg::SQ_W-1:0]        bit_ff, bit_in;
   logic [4:0]                      scnt_ff, scnt_in;
   logic                            strobe_ff, strobe_in;
   logic [31:0]                     mean_ff, mean_in;
   logic [31:0]                     sd_ff, sd_in;
   logic [1:0]                      status_ff, status_in;

   logic                            div_start, div_busy, div_done;
   logic [sms_pkg::DVD_W-1:0]       dividend, quotient;
   logic [sms_pkg::DVS_W-1:0]       divisor;
   logic [sms_pkg::STEP_W-1:0]      steps;

   logic signed [sms_pkg::SUM_W-1:0] sum_mag;
   logic [sms_pkg::M2_W-1:0]        prod_sh;
   logic signed [AW-1:0]            samp_ext, q_signed;
   logic [sms_pkg::SQ_W-1:0]        trial;
   logic [HW-1:0]                   op_a, op_b;

   assign rd_addr     = {bank_ff, idx_ff[sms_pkg::IDX_W-1:0]};
   assign rsp_strobe  = strobe_ff;
   assign rsp_mean    = mean_ff;
   assign rsp_std_dev = sd_ff;
   assign rsp_status  = status_ff;

   sms_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .steps     (steps),
      .div_busy  (div_busy),
      .div_done  (div_done),
      .quotient  (quotient)
   );

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      ovf_in    = ovf_ff;
      bank_in   = bank_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      rvalid_in = 1'b0;
      sum_in    = sum_ff;
      est_in    = est_ff;
      w_in      = w_ff;
      x_in      = x_ff;
      d_in      = d_ff;
      y_in      = y_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      m2_in     = m2_ff;
      mcnt_in   = mcnt_ff;
      prod_in   = prod_ff;
      psh_in    = psh_ff;
      v_in      = v_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      scnt_in   = scnt_ff;
      strobe_in = 1'b0;
      mean_in   = mean_ff;
      sd_in     = sd_ff;
      status_in = status_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      dividend  = '0;
      divisor   = '0;
      steps     = '0;

      sum_mag  = sum_ff[sms_pkg::SUM_W-1] ? -sum_ff : sum_ff;
      samp_ext = {{(AW-SB){rd_data[SB-1]}}, rd_data};
      q_signed = AW'(quotient[sms_pkg::MAG_W-1:0]);
      trial    = res_ff + bit_ff;
      op_a     = mcnt_ff[1] ? a_ff[2*HW-1:HW] : a_ff[HW-1:0];
      op_b     = mcnt_ff[0] ? b_ff[2*HW-1:HW] : b_ff[HW-1:0];
      unique case (psh_ff)
         2'd0:    prod_sh = sms_pkg::M2_W'(prod_ff);
         2'd1:    prod_sh = sms_pkg::M2_W'(prod_ff) << HW;
         default: prod_sh = sms_pkg::M2_W'(prod_ff) << (2*HW);
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               n_in     = head_job.n;
               ovf_in   = head_job.ovf;
               bank_in  = head_job.bank;
               idx_in   = '0;
               acc_in   = '0;
               sum_in   = '0;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (idx_ff < n_ff) begin
               idx_in    = idx_ff + 1'b1;
               rvalid_in = 1'b1;
            end
            if (rvalid_ff) begin
               sum_in = sum_ff + sms_pkg::SUM_W'(samp_ext);
               acc_in = acc_ff + 1'b1;
            end
            if (acc_ff == n_ff && !rvalid_ff) begin
               state_in = S_EST;
            end
         end
         S_EST: begin
            if (n_ff == '0) begin
               est_in   = '0;
               state_in = S_VAR;
            end else begin
               div_start = 1'b1;
               dividend  = {sms_pkg::EST_W'({sum_mag, 16'b0}),
                            {(sms_pkg::DVD_W-sms_pkg::EST_W){1'b0}}};
               divisor   = sms_pkg::DVS_W'(n_ff);
               steps     = sms_pkg::STEP_W'(sms_pkg::EST_W);
               state_in  = S_ESTW;
            end
         end
         S_ESTW: begin
            if (div_done) begin
               est_in   = sum_ff[sms_pkg::SUM_W-1] ?
                          -AW'(quotient[sms_pkg::EST_W-1:0]) :
                          AW'(quotient[sms_pkg::EST_W-1:0]);
               idx_in   = '0;
               w_in     = '0;
               m2_in    = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_X;
         end
         S_X: begin
            x_in     = {samp_ext[AW-1-sms_pkg::FRAC_BITS:0], 16'b0} - est_ff;
            state_in = S_D;
         end
         S_D: begin
            d_in     = x_ff - w_ff;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            a_in      = d_ff[AW-1] ? sms_pkg::MAG_W'(-d_ff) : sms_pkg::MAG_W'(d_ff);
            div_start = 1'b1;
            dividend  = {(d_ff[AW-1] ? sms_pkg::MAG_W'(-d_ff) : sms_pkg::MAG_W'(d_ff)),
                         {(sms_pkg::DVD_W-sms_pkg::MAG_W){1'b0}}};
            divisor   = sms_pkg::DVS_W'(idx_ff) + 1'b1;
            steps     = sms_pkg::STEP_W'(sms_pkg::MAG_W);
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               w_in     = w_ff + (d_ff[AW-1] ? -q_signed : q_signed);
               state_in = S_Y;
            end
         end
         S_Y: begin
            y_in     = x_ff - w_ff;
            state_in = S_AB;
         end
         S_AB: begin
            b_in     = y_ff[AW-1] ? sms_pkg::MAG_W'(-y_ff) : sms_pkg::MAG_W'(y_ff);
            mcnt_in  = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (mcnt_ff != 3'd4) begin
               prod_in = op_a * op_b;
               psh_in  = 2'(mcnt_ff[0]) + 2'(mcnt_ff[1]);
            end
            if (mcnt_ff != 3'd0) begin
               m2_in = m2_ff + prod_sh;
            end
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 3'd4) begin
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff + 1'b1 == n_ff) ? S_VAR : S_RD;
            end
         end
         S_VAR: begin
            if (n_ff < sms_pkg::CNT_W'(2)) begin
               res_in   = '0;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               dividend  = m2_ff;
               divisor   = sms_pkg::DVS_W'(n_ff) - 1'b1;
               steps     = sms_pkg::STEP_W'(sms_pkg::DVD_W);
               state_in  = S_VARW;
            end
         end
         S_VARW: begin
            if (div_done) begin
               v_in     = (quotient[sms_pkg::DVD_W-1:sms_pkg::SQ_W] != '0) ? '1 :
                          quotient[sms_pkg::SQ_W-1:0];
               res_in   = '0;
               bit_in   = sms_pkg::SQ_W'(1) << (sms_pkg::SQ_W - 2);
               scnt_in  = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            scnt_in = scnt_ff + 1'b1;
            if (scnt_ff == 5'd31) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            strobe_in = 1'b1;
            sd_in     = res_ff[31:0];
            if (est_ff > AW'(32'sh7FFF_FFFF)) begin
               mean_in = 32'h7FFF_FFFF;
            end else if (est_ff < -AW'(33'sh0_8000_0000)) begin
               mean_in = 32'h8000_0000;
            end else begin
               mean_in = est_ff[31:0];
            end
            if (n_ff < sms_pkg::CNT_W'(2)) begin
               status_in = sms_pkg::ST_SHORT;
            end else begin
               status_in = ovf_ff ? sms_pkg::ST_OVF : sms_pkg::ST_OK;
            end
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      ovf_ff    <= ovf_in;
      bank_ff   <= bank_in;
      idx_ff    <= idx_in;
      acc_ff    <= acc_in;
      sum_ff    <= sum_in;
      est_ff    <= est_in;
      w_ff      <= w_in;
      x_ff      <= x_in;
      d_ff      <= d_in;
      y_ff      <= y_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      m2_ff     <= m2_in;
      mcnt_ff   <= mcnt_in;
      prod_ff   <= prod_in;
      psh_ff    <= psh_in;
      v_ff      <= v_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      scnt_ff   <= scnt_in;
      mean_ff   <= mean_in;
      sd_ff     <= sd_in;
      status_ff <= status_in;
   end

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while running");

   a_out_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == S_IDLE)
      else $error("result word not followed by idle");

   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == sms_pkg::ST_SHORT |-> rsp_std_dev == 32'd0)
      else $error("short run with nonzero deviation");

endmodule

// File: hdl/sample_mean_stddev.sv
// ----------------------------------------------------------------------------
// sample_mean_stddev
// Mean and sample standard deviation (Q16.16) of a run of signed samples.
// ----------------------------------------------------------------------------
// A sample word is taken each cycle that start is high and busy low; the run
// ends with the word that has req_last_sample set. Samples go into one bank of
// a two-bank buffer, so a new run can be loaded while the previous one is
// computed; busy is high only while both banks hold unfinished runs. The back
// end takes each run through a sum pass, a mean estimate, a Welford pass over
// every sample and the variance, root and output. The shared radix-2 divider
// serves the estimate, each sample and the variance, one quotient bit per
// cycle; the square root then makes one result bit per step.
// Each result word is held on rsp_* for one cycle with rsp_strobe high; the
// receiver cannot stall it.
// ----------------------------------------------------------------------------
module sample_mean_stddev (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_sample,
   input  logic        req_last_sample,
   output logic        rsp_strobe,
   output logic [31:0] rsp_mean,
   output logic [31:0] rsp_std_dev,
   output logic [1:0]  rsp_status
);

   logic                            push, pop, head_valid;
   sms_pkg::job_type                push_job, head_job;
   logic [sms_pkg::ADDR_W-1:0]      rd_addr;
   logic [sms_pkg::SAMPLE_BITS-1:0] rd_data;

   sms_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .job_done        (rsp_strobe),
      .push            (push),
      .push_job        (push_job),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   sms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   sms_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_mean    (rsp_mean),
      .rsp_std_dev (rsp_std_dev),
      .rsp_status  (rsp_status)
   );

endmodule

// File: tb/sample_mean_stddev_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_mean_stddev_test
// Self-checking bench for the run mean / standard deviation block.
// ----------------------------------------------------------------------------
// Sample words are sent as runs: fixed extremes and single-sample runs first,
// then mostly short random runs with one run past the buffer depth. Every
// closed run is predicted in Q16.16 and checked against the result word.
// Sender gaps vary by phase.
// ----------------------------------------------------------------------------

class stats_scoreboard;
   typedef struct {
      logic [31:0] mean;
      logic [31:0] std_dev;
      logic [1:0]  status;
   } stats_word_type;

   longint         run_samples[$];
   bit             run_dropped;
   stats_word_type pending_stats[$];
   int             errors;

   function new();
      run_dropped = 0;
      errors      = 0;
   endfunction

   static function logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_w;
      res   = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v   = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function void predict_stats();
      stats_word_type r;
      longint         n, sum, q, rem, est, w, x, d, y;
      logic [127:0]   m2, prod, var_q;
      logic [63:0]    sd;
      n   = run_samples.size();
      est = 0;
      if (n > 0) begin
         sum = 0;
         foreach (run_samples[i]) sum += run_samples[i];
         q   = sum / n;
         rem = sum % n;
         est = q * 65536 + (rem * 65536) / n;
      end
      w  = 0;
      m2 = 0;
      foreach (run_samples[i]) begin
         x    = run_samples[i] * 65536 - est;
         d    = x - w;
         w    = w + d / longint'(i + 1);
         y    = x - w;
         prod = 128'(d < 0 ? -d : d) * 128'(y < 0 ? -y : y);
         m2   = m2 + prod;
      end
      if (n < 2) begin
         sd       = 0;
         r.status = sms_pkg::ST_SHORT;
      end else begin
         var_q = m2 / 128'(n - 1);
         if (var_q[127:64] != 0) var_q = {64'd0, {64{1'b1}}};
         sd       = floor_root(var_q[63:0]);
         r.status = run_dropped ? sms_pkg::ST_OVF : sms_pkg::ST_OK;
      end
      if (est > 64'sd2147483647) est = 64'sd2147483647;
      if (est < -64'sd2147483648) est = -64'sd2147483648;
      r.mean    = est[31:0];
      r.std_dev = sd[31:0];
      pending_stats.push_back(r);
      run_samples.delete();
      run_dropped = 0;
   endfunction

   function void note_word(logic [15:0] sample, logic last_sample);
      if (run_samples.size() < sms_pkg::MAX_SAMPLES)
         run_samples.push_back(longint'($signed(sample)));
      else
         run_dropped = 1;
      if (last_sample) predict_stats();
   endfunction

   function void check_word(logic [31:0] mean, logic [31:0] std_dev, logic [1:0] status);
      stats_word_type e;
      if (pending_stats.size() == 0) begin
         $error("unexpected result word mean=%h std_dev=%h status=%0d",
                mean, std_dev, status);
         errors++;
         return;
      end
      e = pending_stats.pop_front();
      if (mean !== e.mean) begin
         $error("mean: expected %h, actual %h", e.mean, mean);
         errors++;
      end
      if (std_dev !== e.std_dev) begin
         $error("std_dev: expected %h, actual %h", e.std_dev, std_dev);
         errors++;
      end
      if (status !== e.status) begin
         $error("status: expected %0d, actual %0d", e.status, status);
         errors++;
      end
   endfunction
endclass

module sample_mean_stddev_test;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [15:0] req_sample = 0;
   logic        req_last_sample = 0;
   logic        rsp_strobe;
   logic [31:0] rsp_mean;
   logic [31:0] rsp_std_dev;
   logic [1:0]  rsp_status;

   stats_scoreboard sb = new();
   int idle_pct = 0;
   int words_sent = 0;

   sample_mean_stddev dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample(req_sample), .req_last_sample(req_last_sample),
      .rsp_strobe(rsp_strobe), .rsp_mean(rsp_mean),
      .rsp_std_dev(rsp_std_dev), .rsp_status(rsp_status)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_word(rsp_mean, rsp_std_dev, rsp_status);
   end

   task automatic send_word(logic [15:0] sample, logic last_sample);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start           <= 1;
      req_sample      <= sample;
      req_last_sample <= last_sample;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_word(sample, last_sample);
      words_sent++;
   endtask

   task automatic drain_results();
      start <= 0;
      @(posedge clock);
      while (sb.pending_stats.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(5))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'($signed($urandom_range(20)) - 10);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_run(int len, bit fixed, logic [15:0] value);
      for (int i = 0; i < len; i++)
         send_word(fixed ? value : rand_sample(), i == len - 1);
   endtask

   initial begin
      int len;
      bit big_done;
      big_done = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      idle_pct = 17;
      send_run(1, 1, 16'h7fff);
      send_run(1, 1, 16'h8000);
      send_word(16'h8000, 0);
      send_word(16'h7fff, 1);
      send_run(3, 1, 16'h7fff);
      send_run(4, 1, 16'h8000);
      send_run(3, 1, 16'h0000);
      send_run(2, 1, 16'hffff);
      send_run(5, 0, 16'h0000);
      drain_results();

      while (words_sent < 1550) begin
         if (words_sent > 1050) idle_pct = 0;
         else if (words_sent > 300) idle_pct = 63;
         if (!big_done && words_sent > 350) begin
            drain_results();
            send_run(sms_pkg::MAX_SAMPLES + 1, 0, 16'h0000);
            send_run(2, 0, 16'h0000);
            big_done = 1;
         end
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         send_run(len, 0, 16'h0000);
      end
      drain_results();
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.pending_stats.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #12_000_000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
